### hw/rtl/wlru_pkg.sv
`default_nettype none

package wlru_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_SLOTS_DEF   = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned USAGE_W       = 36;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned SLOT_PORT_W   = 4;
  localparam int unsigned WEIGHT_PORT_W = 32;
  localparam int unsigned STATUS_W      = 2;

  // Register port: two registers at 8-byte spacing, 64-bit data
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;

  localparam logic [USAGE_W-1:0] CAPACITY_RST = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_RECLAIM = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_EVICTED = 2'd2
  } slot_status_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_MRU_MODE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_ADD  = 2'd1,
    ALU_SUB  = 2'd2
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UNLINK,
    S_ADD,
    S_EV_CHK,
    S_EV_RD,
    S_LINK,
    S_FINAL
  } seq_state_e;

  typedef struct packed {
    alu_op_e            op;
    logic [USAGE_W-1:0] a;
    logic [USAGE_W-1:0] b;
    logic [USAGE_W-1:0] bound;
  } alu_req_t;

  typedef struct packed {
    logic [USAGE_W-1:0] res;
    logic               gt;
  } alu_rsp_t;

  typedef struct packed {
    logic [USAGE_W-1:0] capacity;
    logic               mru_mode;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/weighted_lru_mru_replacement_top.sv
// Steps: remove decides, unlinks a queued slot, finishes; reclaim checks the tail, evicts
//   per victim, finishes; update decides, unlinks and/or adds, checks, evicts, links,
//   finishes. One command at a time; the next is taken in the cycle after the final
//   word is loaded. Victims go one per cycle unless stalled, set by the one usage unit.
// Reset: queue empty, usage zero, all slots new (per-slot valid bits), capacity
//   all ones, LRU mode. No clearing pass; commands are taken right after reset.
`default_nettype none

module weighted_lru_mru_replacement_top #(
  parameter int unsigned NUM_SLOTS   = wlru_pkg::NUM_SLOTS_DEF,
  parameter int unsigned WEIGHT_BITS = wlru_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // command channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [wlru_pkg::CMD_W-1:0]          command_i,
  input  wire logic [wlru_pkg::SLOT_PORT_W-1:0]    slot_i,
  input  wire logic                                fresh_i,
  input  wire logic [wlru_pkg::WEIGHT_PORT_W-1:0]  weight_i,
  input  wire logic [wlru_pkg::USAGE_W-1:0]        target_capacity_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [wlru_pkg::SLOT_PORT_W-1:0]    victim_slot_o,
  output logic                                     is_victim_o,
  output logic                                     ignored_o,
  output logic      [wlru_pkg::USAGE_W-1:0]        usage_now_o,
  output logic                                     last_o,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wlru_pkg::APB_AW-1:0]         paddr,
  input  wire logic [wlru_pkg::APB_DW-1:0]         pwdata,
  output logic      [wlru_pkg::APB_DW-1:0]         prdata,
  output logic                                     pready
);

  logic [wlru_pkg::USAGE_W-1:0] cap_q, cap_d;
  logic                         mru_q, mru_d;
  logic                         reg_wr;
  wlru_pkg::reg_idx_e           reg_idx;
  wlru_pkg::cfg_t               cfg;

  // registers sit on 8-byte boundaries; the word offset bit picks one
  assign reg_idx = wlru_pkg::reg_idx_e'(paddr[wlru_pkg::APB_AW-1]);
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cap_d = cap_q;
    mru_d = mru_q;
    if (reg_wr) begin
      unique case (reg_idx)
        wlru_pkg::REG_CAPACITY: cap_d = pwdata[wlru_pkg::USAGE_W-1:0];
        wlru_pkg::REG_MRU_MODE: mru_d = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wlru_pkg::REG_CAPACITY: prdata = wlru_pkg::APB_DW'(cap_q);
      wlru_pkg::REG_MRU_MODE: prdata = wlru_pkg::APB_DW'(mru_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= wlru_pkg::CAPACITY_RST;
      mru_q <= 1'b0;
    end else begin
      cap_q <= cap_d;
      mru_q <= mru_d;
    end
  end

  assign cfg.capacity = cap_q;
  assign cfg.mru_mode = mru_q;

  // Sequencer: slot status/weight and the doubly linked recency list live in
  // small RAMs; one add/subtract/compare unit carries all usage arithmetic.
  wlru_seq #(
    .NUM_SLOTS   (NUM_SLOTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .slot_i            (slot_i),
    .fresh_i           (fresh_i),
    .weight_i          (weight_i),
    .target_capacity_i (target_capacity_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .victim_slot_o     (victim_slot_o),
    .is_victim_o       (is_victim_o),
    .ignored_o         (ignored_o),
    .usage_now_o       (usage_now_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

### hw/rtl/wlru_ram.sv
`default_nettype none

module wlru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/wlru_alu.sv
`default_nettype none

// Shared usage unit: saturating add, flooring subtract or pass, then compare to bound.
module wlru_alu (
  input  wire wlru_pkg::alu_req_t req_i,
  output wlru_pkg::alu_rsp_t      rsp_o
);

  logic [wlru_pkg::USAGE_W:0]   sum;
  logic [wlru_pkg::USAGE_W-1:0] add_sat;
  logic [wlru_pkg::USAGE_W-1:0] sub_floor;
  logic [wlru_pkg::USAGE_W-1:0] res;

  always_comb begin
    sum       = {1'b0, req_i.a} + {1'b0, req_i.b};
    add_sat   = sum[wlru_pkg::USAGE_W] ? '1 : sum[wlru_pkg::USAGE_W-1:0];
    sub_floor = (req_i.a >= req_i.b) ? (req_i.a - req_i.b) : '0;
    case (req_i.op)
      wlru_pkg::ALU_ADD: res = add_sat;
      wlru_pkg::ALU_SUB: res = sub_floor;
      default:           res = req_i.a;
    endcase
  end

  assign rsp_o.res = res;
  assign rsp_o.gt  = res > req_i.bound;

endmodule

`default_nettype wire

### hw/rtl/wlru_seq.sv
`default_nettype none

module wlru_seq #(
  parameter int unsigned NUM_SLOTS   = wlru_pkg::NUM_SLOTS_DEF,
  parameter int unsigned WEIGHT_BITS = wlru_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wlru_pkg::cfg_t                      cfg_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [wlru_pkg::CMD_W-1:0]          command_i,
  input  wire logic [wlru_pkg::SLOT_PORT_W-1:0]    slot_i,
  input  wire logic                                fresh_i,
  input  wire logic [wlru_pkg::WEIGHT_PORT_W-1:0]  weight_i,
  input  wire logic [wlru_pkg::USAGE_W-1:0]        target_capacity_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [wlru_pkg::SLOT_PORT_W-1:0]    victim_slot_o,
  output logic                                     is_victim_o,
  output logic                                     ignored_o,
  output logic      [wlru_pkg::USAGE_W-1:0]        usage_now_o,
  output logic                                     last_o
);

  localparam int unsigned SW    = $clog2(NUM_SLOTS);
  localparam int unsigned CW    = $clog2(NUM_SLOTS + 1);
  localparam int unsigned ENT_W = wlru_pkg::STATUS_W + WEIGHT_BITS;

  wlru_pkg::seq_state_e state_q, state_d;
  wlru_pkg::cmd_e       cmd_q, cmd_d;

  logic [SW-1:0]                slot_q, slot_d;
  logic                         fresh_q, fresh_d;
  logic [WEIGHT_BITS-1:0]       cur_w_q, cur_w_d;
  logic [WEIGHT_BITS-1:0]       sub_w_q, sub_w_d;
  logic                         do_sub_q, do_sub_d;
  logic [wlru_pkg::USAGE_W-1:0] bound_q, bound_d;
  logic                         ign_q, ign_d;
  logic [wlru_pkg::USAGE_W-1:0] usage_q, usage_d;
  logic [SW-1:0]                head_q, head_d;
  logic [SW-1:0]                tail_q, tail_d;
  logic [CW-1:0]                count_q, count_d;
  logic [NUM_SLOTS-1:0]         vld_q;
  logic                         vld_rd_q;

  // output register
  logic                             out_valid_q;
  logic [wlru_pkg::SLOT_PORT_W-1:0] out_victim_q, out_victim_d;
  logic                             out_is_victim_q, out_is_victim_d;
  logic                             out_ign_q, out_ign_d;
  logic [wlru_pkg::USAGE_W-1:0]     out_usage_q, out_usage_d;
  logic                             out_last_q, out_last_d;
  logic                             out_ld;
  logic                             out_free;

  // memories
  logic [SW-1:0]    raddr;
  logic             slot_we;
  logic [SW-1:0]    slot_waddr;
  logic [ENT_W-1:0] slot_wdata;
  logic [ENT_W-1:0] ent_rd;
  logic             nxt_we;
  logic [SW-1:0]    nxt_waddr;
  logic [SW-1:0]    nxt_wdata;
  logic [SW-1:0]    nxt_rd;
  logic             prv_we;
  logic [SW-1:0]    prv_waddr;
  logic [SW-1:0]    prv_wdata;
  logic [SW-1:0]    prv_rd;

  wlru_pkg::alu_req_t alu_req;
  wlru_pkg::alu_rsp_t alu_rsp;

  logic                       in_acc;
  logic [31:0]                slot_ext;
  logic [SW-1:0]              slot_idx;
  logic                       in_range;
  logic [wlru_pkg::STATUS_W-1:0] st_rd;
  logic [WEIGHT_BITS-1:0]     wt_rd;
  logic                       ev_go;
  logic                       ev_more;
  wlru_pkg::seq_state_e       ev_done_state;

  wlru_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (raddr),
    .rdata_o (ent_rd)
  );

  wlru_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (raddr),
    .rdata_o (nxt_rd)
  );

  wlru_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (raddr),
    .rdata_o (prv_rd)
  );

  wlru_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o = (state_q != wlru_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_ext   = 32'(slot_i);
  assign slot_idx   = slot_ext[SW-1:0];
  assign in_range   = slot_ext < 32'(NUM_SLOTS);
  assign out_free   = !out_valid_q || !out_stall_i;

  // never-written entries read as new with zero weight
  assign st_rd = vld_rd_q ? ent_rd[ENT_W-1 -: wlru_pkg::STATUS_W] : wlru_pkg::ST_NEW;
  assign wt_rd = vld_rd_q ? ent_rd[WEIGHT_BITS-1:0] : '0;

  assign ev_go         = alu_rsp.gt && (count_q != '0);
  assign ev_more       = alu_rsp.gt && (count_q > CW'(1));
  assign ev_done_state = (cmd_q == wlru_pkg::CMD_UPDATE) ? wlru_pkg::S_LINK
                                                         : wlru_pkg::S_FINAL;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wlru_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (command_i) inside
            wlru_pkg::CMD_UPDATE, wlru_pkg::CMD_REMOVE: begin
              state_d = in_range ? wlru_pkg::S_DECIDE : wlru_pkg::S_FINAL;
            end
            wlru_pkg::CMD_RECLAIM: state_d = wlru_pkg::S_EV_CHK;
            default:               state_d = wlru_pkg::S_FINAL;
          endcase
        end
      end
      wlru_pkg::S_DECIDE: begin
        if (cmd_q == wlru_pkg::CMD_REMOVE) begin
          if (st_rd == wlru_pkg::ST_QUEUED) begin
            state_d = wlru_pkg::S_UNLINK;
          end else begin
            state_d = wlru_pkg::S_FINAL;
          end
        end else if (fresh_q) begin
          state_d = (st_rd == wlru_pkg::ST_QUEUED) ? wlru_pkg::S_UNLINK : wlru_pkg::S_ADD;
        end else if (st_rd == wlru_pkg::ST_EVICTED) begin
          state_d = wlru_pkg::S_FINAL;
        end else if (st_rd == wlru_pkg::ST_QUEUED) begin
          state_d = wlru_pkg::S_UNLINK;
        end else begin
          state_d = wlru_pkg::S_ADD;
        end
      end
      wlru_pkg::S_UNLINK: begin
        if (cmd_q == wlru_pkg::CMD_REMOVE) begin
          state_d = wlru_pkg::S_FINAL;
        end else begin
          state_d = fresh_q ? wlru_pkg::S_ADD : wlru_pkg::S_EV_CHK;
        end
      end
      wlru_pkg::S_ADD:    state_d = wlru_pkg::S_EV_CHK;
      wlru_pkg::S_EV_CHK: state_d = ev_go ? wlru_pkg::S_EV_RD : ev_done_state;
      wlru_pkg::S_EV_RD: begin
        if (out_free) begin
          state_d = ev_more ? wlru_pkg::S_EV_RD : ev_done_state;
        end
      end
      wlru_pkg::S_LINK:   state_d = wlru_pkg::S_FINAL;
      wlru_pkg::S_FINAL: begin
        if (out_free) begin
          state_d = wlru_pkg::S_IDLE;
        end
      end
      default: state_d = wlru_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d    = cmd_q;
    slot_d   = slot_q;
    fresh_d  = fresh_q;
    cur_w_d  = cur_w_q;
    sub_w_d  = sub_w_q;
    do_sub_d = do_sub_q;
    bound_d  = bound_q;
    ign_d    = ign_q;
    usage_d  = usage_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;

    alu_req.op    = wlru_pkg::ALU_PASS;
    alu_req.a     = usage_q;
    alu_req.b     = '0;
    alu_req.bound = bound_q;

    raddr      = slot_q;
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = {wlru_pkg::ST_QUEUED, cur_w_q};
    nxt_we     = 1'b0;
    nxt_waddr  = slot_q;
    nxt_wdata  = head_q;
    prv_we     = 1'b0;
    prv_waddr  = slot_q;
    prv_wdata  = tail_q;

    out_ld          = 1'b0;
    out_victim_d    = '0;
    out_is_victim_d = 1'b0;
    out_ign_d       = ign_q;
    out_usage_d     = usage_q;
    out_last_d      = 1'b1;

    unique case (state_q)
      wlru_pkg::S_IDLE: begin
        raddr = slot_idx;
        if (in_acc) begin
          cmd_d    = wlru_pkg::cmd_e'(command_i);
          slot_d   = slot_idx;
          fresh_d  = fresh_i;
          cur_w_d  = weight_i[WEIGHT_BITS-1:0];
          do_sub_d = 1'b0;
          bound_d  = (command_i == wlru_pkg::CMD_RECLAIM) ? target_capacity_i
                                                          : cfg_i.capacity;
          ign_d    = ((command_i == wlru_pkg::CMD_UPDATE) ||
                      (command_i == wlru_pkg::CMD_REMOVE)) && !in_range;
        end
      end
      wlru_pkg::S_DECIDE: begin
        if (cmd_q == wlru_pkg::CMD_REMOVE) begin
          if (st_rd == wlru_pkg::ST_EVICTED) begin
            ign_d = 1'b1;
          end else begin
            slot_we    = 1'b1;
            slot_wdata = {wlru_pkg::ST_EVICTED, wt_rd};
            do_sub_d   = (st_rd == wlru_pkg::ST_QUEUED);
            sub_w_d    = wt_rd;
          end
        end else if (fresh_q) begin
          // queued slot gives back its old weight before taking the new one
          do_sub_d = (st_rd == wlru_pkg::ST_QUEUED);
          sub_w_d  = wt_rd;
        end else if (st_rd == wlru_pkg::ST_EVICTED) begin
          ign_d = 1'b1;
        end else begin
          cur_w_d  = wt_rd;
          do_sub_d = 1'b0;
        end
      end
      wlru_pkg::S_UNLINK: begin
        alu_req.op = do_sub_q ? wlru_pkg::ALU_SUB : wlru_pkg::ALU_PASS;
        alu_req.b  = wlru_pkg::USAGE_W'(sub_w_q);
        usage_d    = alu_rsp.res;
        count_d    = count_q - CW'(1);
        if (slot_q == head_q) begin
          head_d = nxt_rd;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = prv_rd;
          nxt_wdata = nxt_rd;
        end
        if (slot_q == tail_q) begin
          tail_d = prv_rd;
        end else begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rd;
          prv_wdata = prv_rd;
        end
      end
      wlru_pkg::S_ADD: begin
        alu_req.op = wlru_pkg::ALU_ADD;
        alu_req.b  = wlru_pkg::USAGE_W'(cur_w_q);
        usage_d    = alu_rsp.res;
      end
      wlru_pkg::S_EV_CHK: begin
        raddr = tail_q;
      end
      wlru_pkg::S_EV_RD: begin
        raddr      = tail_q;
        alu_req.op = wlru_pkg::ALU_SUB;
        alu_req.b  = wlru_pkg::USAGE_W'(wt_rd);
        if (out_free) begin
          // retire the tail, start reading its predecessor
          raddr           = prv_rd;
          slot_we         = 1'b1;
          slot_waddr      = tail_q;
          slot_wdata      = {wlru_pkg::ST_EVICTED, wt_rd};
          usage_d         = alu_rsp.res;
          tail_d          = prv_rd;
          count_d         = count_q - CW'(1);
          out_ld          = 1'b1;
          out_victim_d    = wlru_pkg::SLOT_PORT_W'(tail_q);
          out_is_victim_d = 1'b1;
          out_ign_d       = 1'b0;
          out_usage_d     = alu_rsp.res;
          out_last_d      = 1'b0;
        end
      end
      wlru_pkg::S_LINK: begin
        slot_we = 1'b1;
        count_d = count_q + CW'(1);
        if (count_q == '0) begin
          head_d = slot_q;
          tail_d = slot_q;
        end else if (cfg_i.mru_mode) begin
          prv_we    = 1'b1;
          prv_waddr = slot_q;
          prv_wdata = tail_q;
          nxt_we    = 1'b1;
          nxt_waddr = tail_q;
          nxt_wdata = slot_q;
          tail_d    = slot_q;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = slot_q;
          nxt_wdata = head_q;
          prv_we    = 1'b1;
          prv_waddr = head_q;
          prv_wdata = slot_q;
          head_d    = slot_q;
        end
      end
      wlru_pkg::S_FINAL: begin
        out_ld = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wlru_pkg::S_IDLE;
      usage_q     <= '0;
      count_q     <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      usage_q     <= usage_d;
      count_q     <= count_d;
      out_valid_q <= out_ld || (out_valid_q && out_stall_i);
      if (slot_we) begin
        vld_q[slot_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    slot_q   <= slot_d;
    fresh_q  <= fresh_d;
    cur_w_q  <= cur_w_d;
    sub_w_q  <= sub_w_d;
    do_sub_q <= do_sub_d;
    bound_q  <= bound_d;
    ign_q    <= ign_d;
    head_q   <= head_d;
    tail_q   <= tail_d;
    vld_rd_q <= vld_q[raddr];
    if (out_ld) begin
      out_victim_q    <= out_victim_d;
      out_is_victim_q <= out_is_victim_d;
      out_ign_q       <= out_ign_d;
      out_usage_q     <= out_usage_d;
      out_last_q      <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign victim_slot_o = out_victim_q;
  assign is_victim_o   = out_is_victim_q;
  assign ignored_o     = out_ign_q;
  assign usage_now_o   = out_usage_q;
  assign last_o        = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_SLOTS))
    else $error("queue count above slot count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && out_last_d) |=> (state_q == wlru_pkg::S_IDLE))
    else $error("final word loaded but sequencer not idle");

  a_victim_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wlru_pkg::S_EV_RD && out_free) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("eviction did not shorten the queue by one");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != wlru_pkg::S_IDLE))
    else $error("accepted command did not start");

  a_victim_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_is_victim_q && out_last_q))
    else $error("victim word flagged as last");

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
  import wlru_pkg::*;

  localparam int NSLOT        = NUM_SLOTS_DEF;
  localparam int SETTLE_CYC   = 30;    // > worst update latency, victims included
  localparam int HOLD_CYC     = 150;   // long output hold-off for the squeeze phase
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int PRINT_LIMIT  = 100;
  localparam logic [USAGE_W-1:0] USAGE_ALL = '1;

  // One command word on the input channel
  typedef struct {
    cmd_e                     cmd;
    logic [SLOT_PORT_W-1:0]   slot;
    logic                     fresh;
    logic [WEIGHT_PORT_W-1:0] weight;
    logic [USAGE_W-1:0]       target;
  } cmd_word_t;

  // One result word on the output channel
  typedef struct packed {
    logic [SLOT_PORT_W-1:0] victim_slot;
    logic                   is_victim;
    logic                   ignored;
    logic [USAGE_W-1:0]     usage_now;
    logic                   last;
  } result_word_t;

  typedef enum int {IDLE_OFF, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // DUT ports; the inputs are known from time zero
  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         command_i         = '0;
  logic [SLOT_PORT_W-1:0]   slot_i            = '0;
  logic                     fresh_i           = 1'b0;
  logic [WEIGHT_PORT_W-1:0] weight_i          = '0;
  logic [USAGE_W-1:0]       target_capacity_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i       = 1'b0;
  logic [SLOT_PORT_W-1:0]   victim_slot_o;
  logic                     is_victim_o;
  logic                     ignored_o;
  logic [USAGE_W-1:0]       usage_now_o;
  logic                     last_o;
  logic                     psel              = 1'b0;
  logic                     penable           = 1'b0;
  logic                     pwrite            = 1'b0;
  logic [APB_AW-1:0]        paddr             = '0;
  logic [APB_DW-1:0]        pwdata            = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  // Shadow of the replacement state, kept in step with accepted words
  logic [SLOT_PORT_W-1:0]   lru_chain [NSLOT] = '{default: '0};  // front = index 0
  int                       chain_len         = 0;
  slot_status_e             slot_st   [NSLOT] = '{default: ST_NEW};
  logic [WEIGHT_PORT_W-1:0] slot_wt   [NSLOT] = '{default: '0};
  logic [USAGE_W-1:0]       weight_in_use     = '0;
  logic [USAGE_W-1:0]       cap_cfg           = CAPACITY_RST;
  logic                     mru_cfg           = 1'b0;

  cmd_word_t    cmd_backlog[$];   // words waiting for the driver
  result_word_t due_words[$];     // results predicted but not yet seen
  cmd_word_t    next_word;
  result_word_t head_word;

  idle_mode_e idle_mode     = IDLE_OFF;
  logic       hold_on       = 1'b0;
  logic       squeeze_go    = 1'b0;
  int         words_planned = 0;
  int         words_taken   = 0;
  int         words_seen    = 0;
  int         victims_seen  = 0;
  int         ignored_seen  = 0;
  int         mismatches    = 0;
  int         quiet_cycles  = 0;

  weighted_lru_mru_replacement_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .slot_i           (slot_i),
    .fresh_i          (fresh_i),
    .weight_i         (weight_i),
    .target_capacity_i(target_capacity_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .victim_slot_o    (victim_slot_o),
    .is_victim_o      (is_victim_o),
    .ignored_o        (ignored_o),
    .usage_now_o      (usage_now_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Shadow model of the replacement policy
  // ---------------------------------------------------------------------------

  function automatic void push_result(logic [SLOT_PORT_W-1:0] vs, logic isv, logic ign,
                                      logic lst);
    result_word_t r;
    r.victim_slot = vs;
    r.is_victim   = isv;
    r.ignored     = ign;
    r.usage_now   = weight_in_use;
    r.last        = lst;
    due_words.push_back(r);
  endfunction

  // Usage never drops below zero
  function automatic void give_back(logic [USAGE_W-1:0] w);
    weight_in_use = (weight_in_use >= w) ? weight_in_use - w : '0;
  endfunction

  // Usage saturates at all ones
  function automatic void charge(logic [USAGE_W-1:0] w);
    logic [USAGE_W:0] sum;
    sum = {1'b0, weight_in_use} + {1'b0, w};
    weight_in_use = sum[USAGE_W] ? USAGE_ALL : sum[USAGE_W-1:0];
  endfunction

  function automatic void chain_unlink(logic [SLOT_PORT_W-1:0] s);
    int i;
    int j;
    for (i = 0; i < chain_len; i++) begin
      if (lru_chain[i] == s) begin
        for (j = i; j + 1 < chain_len; j++) lru_chain[j] = lru_chain[j + 1];
        chain_len--;
        return;
      end
    end
  endfunction

  // Evict from the back until 'need' weight is freed or the chain runs dry
  function automatic void evict_tail(logic [USAGE_W-1:0] need);
    logic [63:0]            freed;
    logic [SLOT_PORT_W-1:0] v;
    freed = '0;
    while (freed < 64'(need) && chain_len > 0) begin
      chain_len--;
      v          = lru_chain[chain_len];
      slot_st[v] = ST_EVICTED;
      freed      = freed + 64'(slot_wt[v]);
      give_back(USAGE_W'(slot_wt[v]));
      push_result(v, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  // Expected result words for one accepted command word
  function automatic void apply_command(cmd_e c, logic [SLOT_PORT_W-1:0] s, logic fr,
                                        logic [WEIGHT_PORT_W-1:0] w,
                                        logic [USAGE_W-1:0] tgt);
    int i;
    case (c)
      CMD_UPDATE: begin
        if (fr) begin
          // fresh on a queued slot: drop it and its old weight first
          if (slot_st[s] == ST_QUEUED) begin
            chain_unlink(s);
            give_back(USAGE_W'(slot_wt[s]));
          end
          slot_st[s] = ST_NEW;
          slot_wt[s] = w;
        end
        if (slot_st[s] == ST_EVICTED) begin
          push_result('0, 1'b0, 1'b1, 1'b1);
        end else begin
          // touched slot leaves the chain before eviction, never its own victim
          if (slot_st[s] == ST_NEW) charge(USAGE_W'(slot_wt[s]));
          else chain_unlink(s);
          if (weight_in_use > cap_cfg) evict_tail(weight_in_use - cap_cfg);
          if (chain_len < NSLOT) begin
            if (mru_cfg) begin
              lru_chain[chain_len] = s;
            end else begin
              for (i = chain_len; i > 0; i--) lru_chain[i] = lru_chain[i - 1];
              lru_chain[0] = s;
            end
            chain_len++;
          end
          slot_st[s] = ST_QUEUED;
          push_result('0, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (slot_st[s] == ST_EVICTED) begin
          push_result('0, 1'b0, 1'b1, 1'b1);
        end else begin
          // a new slot was never charged, so nothing to give back
          if (slot_st[s] == ST_QUEUED) begin
            chain_unlink(s);
            give_back(USAGE_W'(slot_wt[s]));
          end
          slot_st[s] = ST_EVICTED;
          push_result('0, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_RECLAIM: begin
        if (weight_in_use > tgt) evict_tail(weight_in_use - tgt);
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
      default: push_result('0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Idle / stall patterns
  // ---------------------------------------------------------------------------

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 72;
      IDLE_BOTH: return $urandom_range(99) < 32;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit recv_gap();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 72;
      IDLE_BOTH: return $urandom_range(99) < 32;
      default:   return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds the command channel from the backlog, predicts on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_command(cmd_e'(command_i), slot_i, fresh_i, weight_i, target_capacity_i);
        words_taken++;
      end
      // a stalled word stays put; otherwise load the next one or go idle
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() != 0 && !send_gap()) begin
          next_word         = cmd_backlog.pop_front();
          in_valid_i        <= 1'b1;
          command_i         <= next_word.cmd;
          slot_i            <= next_word.slot;
          fresh_i           <= next_word.fresh;
          weight_i          <= next_word.weight;
          target_capacity_i <= next_word.target;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_words.size() == 0) begin
          flag_mismatch($sformatf("word %0d: nothing expected, usage_now", words_seen),
                        64'(usage_now_o), 64'h0);
        end else begin
          head_word = due_words.pop_front();
          if (victim_slot_o !== head_word.victim_slot)
            flag_mismatch($sformatf("word %0d victim_slot", words_seen),
                          64'(victim_slot_o), 64'(head_word.victim_slot));
          if (is_victim_o !== head_word.is_victim)
            flag_mismatch($sformatf("word %0d is_victim", words_seen),
                          64'(is_victim_o), 64'(head_word.is_victim));
          if (ignored_o !== head_word.ignored)
            flag_mismatch($sformatf("word %0d ignored", words_seen),
                          64'(ignored_o), 64'(head_word.ignored));
          if (usage_now_o !== head_word.usage_now)
            flag_mismatch($sformatf("word %0d usage_now", words_seen),
                          64'(usage_now_o), 64'(head_word.usage_now));
          if (last_o !== head_word.last)
            flag_mismatch($sformatf("word %0d last", words_seen),
                          64'(last_o), 64'(head_word.last));
          if (head_word.is_victim) victims_seen++;
          if (head_word.ignored) ignored_seen++;
        end
        words_seen++;
      end
      out_stall_i <= hold_on || recv_gap();
    end
  end

  // Long output hold-off: the sender keeps offering, so the block backs up
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Watchdog: too long with no handshake on any port ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Two-phase access; the transfer completes at the edge with pready high
  task automatic reg_access(reg_idx_e idx, logic wr, logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(int'(idx) * 8);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write, read back, and update the shadow config
  task automatic write_reg(reg_idx_e idx, logic [USAGE_W-1:0] val);
    logic [APB_DW-1:0] rd;
    reg_access(idx, 1'b1, APB_DW'(val), rd);
    reg_access(idx, 1'b0, '0, rd);
    if (idx == REG_CAPACITY) begin
      cap_cfg = val;
      if (rd[USAGE_W-1:0] !== val) flag_mismatch("capacity readback", 64'(rd), 64'(val));
    end else begin
      mru_cfg = val[0];
      if (rd[0] !== val[0]) flag_mismatch("mru_mode readback", 64'(rd[0]), 64'(val[0]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic cmd_word_t cw(cmd_e c, int s, logic fr, logic [WEIGHT_PORT_W-1:0] w,
                                   logic [USAGE_W-1:0] tgt);
    cmd_word_t x;
    x.cmd    = c;
    x.slot   = SLOT_PORT_W'(s);
    x.fresh  = fr;
    x.weight = w;
    x.target = tgt;
    return x;
  endfunction

  // Mostly weights near the capacity scale so evictions are common,
  // with a share of full-range and extreme values
  function automatic cmd_word_t random_word(int unsigned wmax, int unsigned tscale);
    cmd_word_t x;
    int        r;
    r = $urandom_range(99);
    x.cmd   = (r < 60) ? CMD_UPDATE : (r < 80) ? CMD_REMOVE : CMD_RECLAIM;
    x.slot  = SLOT_PORT_W'($urandom_range(NSLOT - 1));
    x.fresh = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 80)      x.weight = $urandom_range(wmax);
    else if (r < 92) x.weight = $urandom;
    else if (r < 96) x.weight = '0;
    else             x.weight = '1;
    r = $urandom_range(99);
    if (r < 60)      x.target = USAGE_W'($urandom_range(tscale));
    else if (r < 75) x.target = '0;
    else if (r < 90) x.target = {4'($urandom_range(15)), 32'($urandom)};
    else             x.target = USAGE_ALL;
    return x;
  endfunction

  function automatic void queue_word(cmd_word_t x);
    cmd_backlog.push_back(x);
    words_planned++;
  endfunction

  // Block is idle once every word is taken and every result has arrived
  task automatic drain();
    while (words_taken != words_planned || due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [USAGE_W-1:0] cap, logic mru, idle_mode_e im, int n,
                           int unsigned wmax, int unsigned tscale, bit squeeze);
    int k;
    drain();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_MRU_MODE, USAGE_W'(mru));
    idle_mode = im;
    for (k = 0; k < n; k++) queue_word(random_word(wmax, tscale));
    if (squeeze) squeeze_go = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset config (no eviction by update, LRU order)
    queue_word(cw(CMD_UPDATE,   0, 1'b1, '0,            '0));  // zero weight
    queue_word(cw(CMD_UPDATE,  15, 1'b1, '1,            '0));  // max weight
    queue_word(cw(CMD_UPDATE,   3, 1'b1, 100,           '0));
    queue_word(cw(CMD_UPDATE,   5, 1'b0, 32'h1234,      '0));  // never-seen slot, not fresh
    queue_word(cw(CMD_UPDATE,   0, 1'b0, 32'h5678,      '0));  // touch of a queued slot
    queue_word(cw(CMD_UPDATE,   3, 1'b1, 200,           '0));  // fresh on queued slot
    queue_word(cw(CMD_REMOVE,  15, 1'b0, '0,            '0));  // remove queued
    queue_word(cw(CMD_REMOVE,   9, 1'b1, '0,            '0));  // remove new
    queue_word(cw(CMD_REMOVE,   9, 1'b0, '0,            '0));  // remove evicted
    queue_word(cw(CMD_UPDATE,   9, 1'b0, 5,             '0));  // touch evicted
    queue_word(cw(CMD_UPDATE,   9, 1'b1, 7,             '0));  // fresh revives evicted
    queue_word(cw(CMD_UPDATE,  12, 1'b1, 32'h8000_0001, '0));
    queue_word(cw(CMD_RECLAIM,  0, 1'b0, '0,            USAGE_ALL));
    queue_word(cw(CMD_RECLAIM,  0, 1'b0, '0,            USAGE_W'(150)));
    queue_word(cw(CMD_RECLAIM,  0, 1'b1, '0,            '0));  // chain already empty, nothing to evict
    queue_word(cw(CMD_REMOVE,   3, 1'b0, '0,            '0));

    // Directed, zero capacity and MRU: chain runs dry before usage fits
    drain();
    write_reg(REG_CAPACITY, '0);
    write_reg(REG_MRU_MODE, USAGE_W'(1));
    queue_word(cw(CMD_UPDATE,   1, 1'b1, 10,            '0));  // nothing left to evict
    queue_word(cw(CMD_UPDATE,   2, 1'b1, '0,            '0));  // touched slot is spared
    queue_word(cw(CMD_UPDATE,   4, 1'b1, 1,             '0));
    queue_word(cw(CMD_UPDATE,   6, 1'b1, 3,             '0));
    queue_word(cw(CMD_UPDATE,   4, 1'b0, '0,            '0));
    queue_word(cw(CMD_RECLAIM,  0, 1'b0, '0,            '0));
    queue_word(cw(CMD_UPDATE,   7, 1'b1, '1,            '0));

    // Random phases: capacity, order mode, idle pattern
    run_phase(USAGE_W'(250),                1'b0, IDLE_OFF,  35, 120,  500, 1'b0);
    run_phase(USAGE_W'(250),                1'b1, IDLE_SEND, 35, 120,  500, 1'b0);
    run_phase(USAGE_W'(1000),               1'b0, IDLE_RECV, 35, 400, 2000, 1'b0);
    run_phase('0,                           1'b1, IDLE_BOTH, 35,  50,  100, 1'b0);
    run_phase(USAGE_ALL,                    1'b0, IDLE_BOTH, 35, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b0);
    run_phase(USAGE_W'($urandom_range(600, 100)), 1'b1, IDLE_OFF, 35, 150, 600, 1'b1);
    drain();

    $display("summary: %0d command words over capacities from zero to full scale,",
             words_taken);
    $display("summary: LRU and MRU, four idle patterns, one long output hold;");
    $display("summary: %0d results, %0d evictions, %0d ignored",
             words_seen, victims_seen, ignored_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
